// File: sv/slru_pkg.sv
`timescale 1ns / 1ps

package slru_pkg;

    // fixed widths of the transfer fields
    localparam int MODE_W     = 3;
    localparam int TAG_W      = 32;
    localparam int WAY_W      = 3;
    localparam int TIER_W     = 2;
    localparam int TOUCH_BITS = 5;

    localparam logic [TOUCH_BITS-1:0] TOUCH_MAX       = 5'd31;
    localparam logic [TOUCH_BITS-1:0] PROMOTE_TOUCHES = 5'd2;

    typedef enum logic [MODE_W-1:0] {
        MODE_LOOKUP   = 3'd0,
        MODE_VICTIM   = 3'd1,
        MODE_INSTALL  = 3'd2,
        MODE_HIT      = 3'd3,
        MODE_PREFETCH = 3'd4,
        MODE_RESET    = 3'd5
    } mode_t;

    typedef enum logic [TIER_W-1:0] {
        TIER_INVALID   = 2'd0,
        TIER_PROBATION = 2'd1,
        TIER_PROTECTED = 2'd2
    } tier_t;

    typedef enum logic [2:0] {
        LIST_HOLD,
        LIST_REMOVE,
        LIST_REFRESH,
        LIST_POP,
        LIST_CLEAR
    } list_op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_UPDATE
    } state_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [TAG_W-1:0]  tag;
        logic [WAY_W-1:0]  way;
    } item_t;

    typedef struct packed {
        logic              hit;
        logic [WAY_W-1:0]  hit_way;
        logic [WAY_W-1:0]  victim_way;
        logic              victim_valid;
        logic [TIER_W-1:0] victim_tier;
    } result_t;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic search;
        logic update;
    } cmd_t;

endpackage

// File: sv/segmented_lru_set_replacement.sv
`timescale 1ns / 1ps
// Segmented LRU replacement state for one cache set of WAYS ways.
// Request channel: a transfer is taken at a rising edge with start high and
// busy low; item carries mode, tag and way. Modes: lookup, pick victim,
// install, demand hit, prefetch touch and a soft reset of the set state.
// Result channel: done is high for exactly one cycle with result valid;
// every request gives exactly one result. The receiver cannot stall, so a
// result must be taken in the cycle it is shown.
// The request passes the search state for the parallel tag compare and
// victim choice, the update state for the recency list shift and line
// writes, then the result register.
// A new request can be taken during the update state, before the last
// result is shown; busy is high only in the search cycle.
// Reset: rst_n clears valid bits, touch counts, tiers and both list lengths
// at once; the block accepts a request in the first cycle after reset.
// The protected tier has no capacity bound.

module segmented_lru_set_replacement #(
    parameter int WAYS     = 8,
    parameter int TAG_BITS = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  slru_pkg::item_t   item,
    output logic              done,
    output slru_pkg::result_t result
);

    slru_pkg::cmd_t cmd;

    slru_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd)
    );

    slru_dp #(
        .WAYS     (WAYS),
        .TAG_BITS (TAG_BITS)
    ) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .item   (item),
        .result (result)
    );

endmodule

// File: sv/slru_list.sv
`timescale 1ns / 1ps

module slru_list #(
    parameter int WAYS = 8,
    localparam int IDX_W = (WAYS > 1) ? $clog2(WAYS) : 1,
    localparam int LEN_W = $clog2(WAYS + 1)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  slru_pkg::list_op_t   op,
    input  logic [IDX_W-1:0]     target,
    output logic [LEN_W-1:0]     len,
    output logic [IDX_W-1:0]     lru
);

    logic [IDX_W-1:0] ent_reg  [WAYS];
    logic [IDX_W-1:0] ent_next [WAYS];
    logic [IDX_W-1:0] up_src   [WAYS];
    logic [IDX_W-1:0] dn_src   [WAYS];
    logic [LEN_W-1:0] len_reg;
    logic [LEN_W-1:0] len_next;
    logic [LEN_W-1:0] lru_pos;
    logic [WAYS-1:0]  match;
    logic [WAYS-1:0]  past_hit;
    logic             found;

    // neighbor entries for the shift toward lru and toward mru
    genvar g;
    generate
        for (g = 0; g < WAYS; g++)
        begin : g_src
            if (g < WAYS - 1)
            begin : g_up
                assign up_src[g] = ent_reg[g + 1];
            end
            else
            begin : g_up_last
                assign up_src[g] = ent_reg[g];
            end
            if (g > 0)
            begin : g_dn
                assign dn_src[g] = ent_reg[g - 1];
            end
            else
            begin : g_dn_first
                assign dn_src[g] = target;
            end
        end
    endgenerate

    // locate the target among live entries
    always_comb
    begin
        for (int i = 0; i < WAYS; i++)
        begin
            match[i] = (ent_reg[i] == target) && (i < len_reg);
        end
        past_hit[0] = 1'b0;
        for (int i = 1; i < WAYS; i++)
        begin
            past_hit[i] = past_hit[i - 1] | match[i - 1];
        end
        found = |match;
    end

    // next list contents
    always_comb
    begin
        for (int i = 0; i < WAYS; i++)
        begin
            ent_next[i] = ent_reg[i];
        end
        len_next = len_reg;
        case (op)
            slru_pkg::LIST_REMOVE:
            begin
                for (int i = 0; i < WAYS; i++)
                begin
                    if (past_hit[i] || match[i])
                    begin
                        ent_next[i] = up_src[i];
                    end
                end
                len_next = len_reg - LEN_W'(found);
            end
            slru_pkg::LIST_REFRESH:
            begin
                // entries above the old position slide down one, target at mru
                for (int i = 0; i < WAYS; i++)
                begin
                    if (!past_hit[i])
                    begin
                        ent_next[i] = dn_src[i];
                    end
                end
                if (!found && (len_reg != LEN_W'(WAYS)))
                begin
                    len_next = len_reg + LEN_W'(1);
                end
            end
            slru_pkg::LIST_POP:
            begin
                len_next = len_reg - LEN_W'(1);
            end
            slru_pkg::LIST_CLEAR:
            begin
                len_next = '0;
            end
            default:
            begin
                len_next = len_reg;
            end
        endcase
    end

    // entries carry no reset, only the length does
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < WAYS; i++)
        begin
            ent_reg[i] <= ent_next[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= '0;
        end
        else
        begin
            len_reg <= len_next;
        end
    end

    assign lru_pos = len_reg - LEN_W'(1);
    assign lru     = ent_reg[lru_pos[IDX_W-1:0]];
    assign len     = len_reg;

endmodule

// File: sv/slru_ctrl.sv
`timescale 1ns / 1ps

module slru_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    output logic           done,
    output slru_pkg::cmd_t cmd
);

    slru_pkg::state_t state_reg;
    slru_pkg::state_t state_next;
    logic             done_reg;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= slru_pkg::ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == slru_pkg::ST_UPDATE);
        end
    end

    // next state and commands; a new transfer is taken during update
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b0;
        case (state_reg)
            slru_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = slru_pkg::ST_SEARCH;
                end
            end
            slru_pkg::ST_SEARCH:
            begin
                busy       = 1'b1;
                cmd.search = 1'b1;
                state_next = slru_pkg::ST_UPDATE;
            end
            slru_pkg::ST_UPDATE:
            begin
                cmd.update = 1'b1;
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = slru_pkg::ST_SEARCH;
                end
                else
                begin
                    state_next = slru_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = slru_pkg::ST_IDLE;
            end
        endcase
    end

    assign done = done_reg;

endmodule

// File: sv/slru_dp.sv
`timescale 1ns / 1ps

module slru_dp #(
    parameter int WAYS     = 8,
    parameter int TAG_BITS = 32,
    localparam int IDX_W = (WAYS > 1) ? $clog2(WAYS) : 1,
    localparam int LEN_W = $clog2(WAYS + 1)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  slru_pkg::cmd_t    cmd,
    input  slru_pkg::item_t   item,
    output slru_pkg::result_t result
);

    localparam int WAY_W = slru_pkg::WAY_W;
    localparam int TB    = slru_pkg::TOUCH_BITS;

    // per-way line state
    logic                valid_reg [WAYS];
    logic [TAG_BITS-1:0] tag_reg   [WAYS];
    logic [TB-1:0]       touch_reg [WAYS];
    slru_pkg::tier_t     tier_reg  [WAYS];

    // latched request and search results
    slru_pkg::item_t     item_reg;
    logic                hit_reg;
    logic [IDX_W-1:0]    hit_way_reg;
    logic [IDX_W-1:0]    target_reg;
    logic                inv_found_reg;
    logic                pop_prob_reg;
    logic                pop_prot_reg;
    logic                way_ok_reg;
    slru_pkg::result_t   result_reg;

    logic                hit_next;
    logic [IDX_W-1:0]    hit_way_next;
    logic [IDX_W-1:0]    target_next;
    logic                inv_found_next;
    logic                pop_prob_next;
    logic                pop_prot_next;
    logic                way_ok_next;
    slru_pkg::result_t   result_next;

    logic [TAG_BITS+slru_pkg::TAG_W-1:0] tag_ext;
    logic [TAG_BITS-1:0] tag_k;
    logic [IDX_W+WAY_W-1:0] way_ext;
    logic [IDX_W-1:0]    way_idx;
    logic [IDX_W-1:0]    inv_idx;
    logic [WAY_W+IDX_W-1:0] hit_way_ext;
    logic [WAY_W+IDX_W-1:0] target_ext;

    // list interface
    slru_pkg::list_op_t  prob_op;
    slru_pkg::list_op_t  prot_op;
    logic [LEN_W-1:0]    prob_len;
    logic [LEN_W-1:0]    prot_len;
    logic [IDX_W-1:0]    prob_lru;
    logic [IDX_W-1:0]    prot_lru;

    // update controls
    slru_pkg::tier_t     cur_tier;
    logic [TB-1:0]       cur_touch;
    logic [TB-1:0]       touch_inc;
    logic                promote;
    logic                wr_install;
    logic                wr_touch;
    logic                wr_promote;
    logic                clear_all;

    slru_list #(.WAYS(WAYS)) u_prob (
        .clk    (clk),
        .rst_n  (rst_n),
        .op     (prob_op),
        .target (target_reg),
        .len    (prob_len),
        .lru    (prob_lru)
    );

    slru_list #(.WAYS(WAYS)) u_prot (
        .clk    (clk),
        .rst_n  (rst_n),
        .op     (prot_op),
        .target (target_reg),
        .len    (prot_len),
        .lru    (prot_lru)
    );

    // fit the request fields to the configured widths
    assign tag_ext = {{TAG_BITS{1'b0}}, item_reg.tag};
    assign tag_k   = tag_ext[TAG_BITS-1:0];
    assign way_ext = {{IDX_W{1'b0}}, item_reg.way};
    assign way_idx = way_ext[IDX_W-1:0];

    // search: tag compare, first free way, victim choice
    always_comb
    begin
        hit_next     = 1'b0;
        hit_way_next = '0;
        inv_found_next = 1'b0;
        inv_idx      = '0;
        for (int i = 0; i < WAYS; i++)
        begin
            if (!hit_next && valid_reg[i] && (tag_reg[i] == tag_k))
            begin
                hit_next     = 1'b1;
                hit_way_next = IDX_W'(i);
            end
            if (!inv_found_next && !valid_reg[i])
            begin
                inv_found_next = 1'b1;
                inv_idx        = IDX_W'(i);
            end
        end
        way_ok_next   = (32'(item_reg.way) < WAYS);
        pop_prob_next = 1'b0;
        pop_prot_next = 1'b0;
        target_next   = way_idx;
        if (item_reg.mode == slru_pkg::MODE_VICTIM)
        begin
            if (inv_found_next)
            begin
                target_next = inv_idx;
            end
            else if (prob_len != '0)
            begin
                target_next   = prob_lru;
                pop_prob_next = 1'b1;
            end
            else if (prot_len != '0)
            begin
                target_next   = prot_lru;
                pop_prot_next = 1'b1;
            end
            else
            begin
                target_next = '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= item;
        end
        if (cmd.search)
        begin
            hit_reg       <= hit_next;
            hit_way_reg   <= hit_way_next;
            target_reg    <= target_next;
            inv_found_reg <= inv_found_next;
            pop_prob_reg  <= pop_prob_next;
            pop_prot_reg  <= pop_prot_next;
            way_ok_reg    <= way_ok_next;
        end
    end

    assign cur_tier    = tier_reg[target_reg];
    assign cur_touch   = touch_reg[target_reg];
    assign touch_inc   = (cur_touch == slru_pkg::TOUCH_MAX) ? cur_touch : cur_touch + TB'(1);
    assign promote     = (cur_tier == slru_pkg::TIER_PROBATION) &&
                         (touch_inc >= slru_pkg::PROMOTE_TOUCHES);
    assign hit_way_ext = {{WAY_W{1'b0}}, hit_way_reg};
    assign target_ext  = {{WAY_W{1'b0}}, target_reg};

    // update: list commands, line writes and the result
    always_comb
    begin
        prob_op     = slru_pkg::LIST_HOLD;
        prot_op     = slru_pkg::LIST_HOLD;
        wr_install  = 1'b0;
        wr_touch    = 1'b0;
        wr_promote  = 1'b0;
        clear_all   = 1'b0;
        result_next = '0;
        if (cmd.update)
        begin
            case (item_reg.mode)
                slru_pkg::MODE_LOOKUP:
                begin
                    result_next.hit     = hit_reg;
                    result_next.hit_way = hit_way_ext[WAY_W-1:0];
                end
                slru_pkg::MODE_VICTIM:
                begin
                    result_next.victim_way   = target_ext[WAY_W-1:0];
                    result_next.victim_valid = valid_reg[target_reg];
                    result_next.victim_tier  = cur_tier;
                    if (inv_found_reg)
                    begin
                        prob_op = slru_pkg::LIST_REMOVE;
                        prot_op = slru_pkg::LIST_REMOVE;
                    end
                    else if (pop_prob_reg)
                    begin
                        prob_op = slru_pkg::LIST_POP;
                    end
                    else if (pop_prot_reg)
                    begin
                        prot_op = slru_pkg::LIST_POP;
                    end
                end
                slru_pkg::MODE_INSTALL:
                begin
                    if (way_ok_reg)
                    begin
                        prob_op    = slru_pkg::LIST_REFRESH;
                        prot_op    = slru_pkg::LIST_REMOVE;
                        wr_install = 1'b1;
                    end
                end
                slru_pkg::MODE_HIT:
                begin
                    if (way_ok_reg)
                    begin
                        wr_touch = 1'b1;
                        if (promote)
                        begin
                            prob_op    = slru_pkg::LIST_REMOVE;
                            prot_op    = slru_pkg::LIST_REFRESH;
                            wr_promote = 1'b1;
                        end
                        else if (cur_tier == slru_pkg::TIER_PROBATION)
                        begin
                            prob_op = slru_pkg::LIST_REFRESH;
                        end
                        else if (cur_tier == slru_pkg::TIER_PROTECTED)
                        begin
                            prot_op = slru_pkg::LIST_REFRESH;
                        end
                    end
                end
                slru_pkg::MODE_PREFETCH:
                begin
                    if (way_ok_reg)
                    begin
                        if (cur_tier == slru_pkg::TIER_PROBATION)
                        begin
                            prob_op = slru_pkg::LIST_REFRESH;
                        end
                        else if (cur_tier == slru_pkg::TIER_PROTECTED)
                        begin
                            prot_op = slru_pkg::LIST_REFRESH;
                        end
                    end
                end
                slru_pkg::MODE_RESET:
                begin
                    prob_op   = slru_pkg::LIST_CLEAR;
                    prot_op   = slru_pkg::LIST_CLEAR;
                    clear_all = 1'b1;
                end
                default:
                begin
                    result_next = '0;
                end
            endcase
        end
    end

    // line state with reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WAYS; i++)
            begin
                valid_reg[i] <= 1'b0;
                touch_reg[i] <= '0;
                tier_reg[i]  <= slru_pkg::TIER_INVALID;
            end
        end
        else if (clear_all)
        begin
            for (int i = 0; i < WAYS; i++)
            begin
                valid_reg[i] <= 1'b0;
                touch_reg[i] <= '0;
                tier_reg[i]  <= slru_pkg::TIER_INVALID;
            end
        end
        else
        begin
            if (wr_install)
            begin
                valid_reg[target_reg] <= 1'b1;
                touch_reg[target_reg] <= TB'(1);
                tier_reg[target_reg]  <= slru_pkg::TIER_PROBATION;
            end
            if (wr_touch)
            begin
                touch_reg[target_reg] <= touch_inc;
            end
            if (wr_promote)
            begin
                tier_reg[target_reg] <= slru_pkg::TIER_PROTECTED;
            end
        end
    end

    // tags are only seen through a valid way
    always_ff @(posedge clk)
    begin
        if (wr_install)
        begin
            tag_reg[target_reg] <= tag_k;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_reg <= '0;
        end
        else if (cmd.update)
        begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule

// File: sv/slru_checker.sv
`timescale 1ns / 1ps

module slru_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input logic              done,
    input slru_pkg::result_t result
);

    // every accepted transfer gives a result
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> ##2 done)
        else $error("result missing after accepted request");

    // no result without an earlier accepted request
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 3))
        else $error("result without request");

    // lookup fields and victim fields are never both active
    a_fields_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.hit || (result.hit_way != '0))) |->
        ((result.victim_way == '0) && !result.victim_valid && (result.victim_tier == '0)))
        else $error("lookup and victim fields both set");

    // a victim holds a valid line exactly when it sits in a tier
    a_victim_tier: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.victim_valid == (result.victim_tier != slru_pkg::TIER_INVALID)))
        else $error("victim valid and tier disagree");

endmodule

bind segmented_lru_set_replacement slru_checker u_checker (.*);
